@@ rtl/fxa_pkg.sv @@
// Shared types, constants and arithmetic helpers of the filtered-x NLMS noise canceller.
package fxa_pkg;

  localparam int unsigned MAX_TAPS_DEF = 256;
  localparam int unsigned NUM_CH_DEF   = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned SAMPLE_W   = 16;

  localparam int unsigned REM_STEPS = 10;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned WIDE_W    = 96;

  localparam logic [8:0]  TAPS_RST  = 9'd128;
  localparam logic [15:0] STEP_RST  = 16'd819;
  localparam logic [15:0] LEAK_RST  = 16'd32768;
  localparam logic [30:0] EPS_RST   = 31'd1074;
  localparam logic [15:0] GAIN_RST  = 16'd4096;
  localparam logic [9:0]  DELAY_RST = 10'd3;

  typedef enum logic [2:0] {
    REG_TAPS  = 3'd0,
    REG_STEP  = 3'd1,
    REG_LEAK  = 3'd2,
    REG_EPS   = 3'd3,
    REG_GAIN  = 3'd4,
    REG_DELAY = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_REM, ST_SETUP, ST_PASS1, ST_DRAIN1, ST_YQ,
    ST_GY, ST_ERR, ST_ME, ST_DIV, ST_PASS2, ST_DRAIN2, ST_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_REM, OP_SETUP, OP_PASS1, OP_YQ,
    OP_GY, OP_ERR, OP_ME, OP_DIV, OP_PASS2, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic pipe_empty;
    logic out_free;
  } dp_status_t;

  localparam logic signed [WIDE_W-1:0] S16_MAX = WIDE_W'(64'sd32767);
  localparam logic signed [WIDE_W-1:0] S16_MIN = -S16_MAX - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] S32_MAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] S32_MIN = -S32_MAX - WIDE_W'(1);

  // Right shift that rounds the magnitude half away from zero.
  function automatic logic signed [WIDE_W-1:0] rnd(input logic signed [WIDE_W-1:0] v,
                                                   input int unsigned s);
    logic [WIDE_W-1:0] m;
    logic              neg;
    neg = v[WIDE_W-1];
    m = neg ? WIDE_W'(-v) : WIDE_W'(v);
    m = (m + (WIDE_W'(1) << (s - 1))) >> s;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [15:0] r;
    if (v > S16_MAX) r = 16'sh7FFF;
    else if (v < S16_MIN) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

@@ rtl/fxa_in_if.sv @@
// Input sample channel: channel index, reference sample and microphone sample.
interface fxa_in_if;
  logic              valid;
  logic              ready;
  logic              channel;
  logic signed [15:0] reference_sample;
  logic signed [15:0] mic_sample;

  modport source (output valid, channel, reference_sample, mic_sample, input ready);
  modport sink   (input valid, channel, reference_sample, mic_sample, output ready);
endinterface

@@ rtl/fxa_out_if.sv @@
// Result channel: channel index, anti-noise sample and residual error.
interface fxa_out_if;
  logic              valid;
  logic              ready;
  logic              out_channel;
  logic signed [15:0] anti_noise;
  logic signed [15:0] residual;

  modport source (output valid, out_channel, anti_noise, residual, input ready);
  modport sink   (input valid, out_channel, anti_noise, residual, output ready);
endinterface

@@ rtl/fxa_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface fxa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fxa_pkg::CFG_IDX_W-1:0]  index;
  logic [fxa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/fxa_ctrl.sv @@
// Sequencer that steps the datapath through clearing, both tap passes and the division.
module fxa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  fxa_pkg::dp_status_t   status_i,
  output fxa_pkg::dp_cmd_t      cmd_o
);

  fxa_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fxa_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fxa_pkg::ST_CLEAR:  if (status_i.last) state_d = fxa_pkg::ST_IDLE;
      fxa_pkg::ST_IDLE:   if (in_valid_i) state_d = fxa_pkg::ST_REM;
      fxa_pkg::ST_REM:    if (status_i.last) state_d = fxa_pkg::ST_SETUP;
      fxa_pkg::ST_SETUP:  state_d = fxa_pkg::ST_PASS1;
      fxa_pkg::ST_PASS1:  if (status_i.last) state_d = fxa_pkg::ST_DRAIN1;
      fxa_pkg::ST_DRAIN1: if (status_i.pipe_empty) state_d = fxa_pkg::ST_YQ;
      fxa_pkg::ST_YQ:     state_d = fxa_pkg::ST_GY;
      fxa_pkg::ST_GY:     state_d = fxa_pkg::ST_ERR;
      fxa_pkg::ST_ERR:    state_d = fxa_pkg::ST_ME;
      fxa_pkg::ST_ME:     state_d = fxa_pkg::ST_DIV;
      fxa_pkg::ST_DIV:    if (status_i.last) state_d = fxa_pkg::ST_PASS2;
      fxa_pkg::ST_PASS2:  if (status_i.last) state_d = fxa_pkg::ST_DRAIN2;
      fxa_pkg::ST_DRAIN2: if (status_i.pipe_empty) state_d = fxa_pkg::ST_OUT;
      fxa_pkg::ST_OUT:    if (status_i.out_free) state_d = fxa_pkg::ST_IDLE;
      default:            state_d = fxa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = fxa_pkg::OP_NONE;
    unique case (state_q)
      fxa_pkg::ST_CLEAR: cmd_o.op = fxa_pkg::OP_CLEAR;
      fxa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = fxa_pkg::OP_LOAD;
      end
      fxa_pkg::ST_REM:    cmd_o.op = fxa_pkg::OP_REM;
      fxa_pkg::ST_SETUP:  cmd_o.op = fxa_pkg::OP_SETUP;
      fxa_pkg::ST_PASS1:  cmd_o.op = fxa_pkg::OP_PASS1;
      fxa_pkg::ST_YQ:     cmd_o.op = fxa_pkg::OP_YQ;
      fxa_pkg::ST_GY:     cmd_o.op = fxa_pkg::OP_GY;
      fxa_pkg::ST_ERR:    cmd_o.op = fxa_pkg::OP_ERR;
      fxa_pkg::ST_ME:     cmd_o.op = fxa_pkg::OP_ME;
      fxa_pkg::ST_DIV:    cmd_o.op = fxa_pkg::OP_DIV;
      fxa_pkg::ST_PASS2:  cmd_o.op = fxa_pkg::OP_PASS2;
      fxa_pkg::ST_OUT:    if (status_i.out_free) cmd_o.op = fxa_pkg::OP_OUT;
      default:            cmd_o.op = fxa_pkg::OP_NONE;
    endcase
  end

endmodule

@@ rtl/fxa_datapath.sv @@
// Datapath: configuration registers, weight and history memories, MAC pipelines and divider.
module fxa_datapath #(
  parameter int unsigned MAX_TAPS     = fxa_pkg::MAX_TAPS_DEF,
  parameter int unsigned NUM_CHANNELS = fxa_pkg::NUM_CH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fxa_pkg::dp_cmd_t               cmd_i,
  output fxa_pkg::dp_status_t            status_o,
  input  logic                           in_channel_i,
  input  logic signed [15:0]             in_reference_sample_i,
  input  logic signed [15:0]             in_mic_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_channel_o,
  output logic signed [15:0]             out_anti_noise_o,
  output logic signed [15:0]             out_residual_o,
  input  logic                           cfg_valid_i,
  input  logic [fxa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fxa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH  = NUM_CHANNELS * MAX_TAPS;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned LW     = $clog2(MAX_TAPS + 1);
  localparam int unsigned CW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W  = (AW + 1 > 7) ? AW + 1 : 7;
  localparam int unsigned ACC_W  = 49 + TW;
  localparam int unsigned YQ_W   = ACC_W - 27;
  localparam int unsigned GY_W   = YQ_W + 17;
  localparam int unsigned NORM_W = 39 + TW;
  localparam int unsigned DEN_W  = NORM_W + 1;
  localparam int unsigned WW     = fxa_pkg::WIDE_W;

  // Configuration registers.
  logic [8:0]  taps_q;
  logic [15:0] step_q, leak_q, gain_q;
  logic [30:0] eps_q;
  logic [9:0]  delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q  <= fxa_pkg::TAPS_RST;
      step_q  <= fxa_pkg::STEP_RST;
      leak_q  <= fxa_pkg::LEAK_RST;
      eps_q   <= fxa_pkg::EPS_RST;
      gain_q  <= fxa_pkg::GAIN_RST;
      delay_q <= fxa_pkg::DELAY_RST;
    end else if (cfg_valid_i) begin
      unique case (fxa_pkg::cfg_reg_e'(cfg_index_i))
        fxa_pkg::REG_TAPS:  taps_q  <= cfg_data_i[8:0];
        fxa_pkg::REG_STEP:  step_q  <= cfg_data_i[15:0];
        fxa_pkg::REG_LEAK:  leak_q  <= cfg_data_i[15:0];
        fxa_pkg::REG_EPS:   eps_q   <= cfg_data_i[30:0];
        fxa_pkg::REG_GAIN:  gain_q  <= cfg_data_i[15:0];
        fxa_pkg::REG_DELAY: delay_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Taps in use, clamped to 1..MAX_TAPS.
  logic [LW-1:0] len;
  logic [TW-1:0] lm1;
  always_comb begin
    if (taps_q == 9'd0) len = LW'(1);
    else if (32'(taps_q) > 32'(MAX_TAPS)) len = LW'(MAX_TAPS);
    else len = LW'(taps_q);
    lm1 = TW'(len - LW'(1));
  end

  fxa_pkg::dp_op_e op;
  assign op = cmd_i.op;

  // Shared step counter for clearing, remainder, tap passes and division.
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             counting;
  logic             last;
  logic [TW-1:0]    k;

  assign counting = (op == fxa_pkg::OP_CLEAR) || (op == fxa_pkg::OP_REM) ||
                    (op == fxa_pkg::OP_PASS1) || (op == fxa_pkg::OP_DIV) ||
                    (op == fxa_pkg::OP_PASS2);
  // The count restarts after the last step, since division runs straight into pass 2.
  assign cnt_d = (counting && !last) ? cnt_q + CNT_W'(1) : '0;
  assign k     = cnt_q[TW-1:0];

  always_comb begin
    unique case (op)
      fxa_pkg::OP_CLEAR: last = (cnt_q == CNT_W'(DEPTH - 1));
      fxa_pkg::OP_REM:   last = (cnt_q == CNT_W'(fxa_pkg::REM_STEPS - 1));
      fxa_pkg::OP_PASS1,
      fxa_pkg::OP_PASS2: last = (cnt_q == CNT_W'(lm1));
      fxa_pkg::OP_DIV:   last = (cnt_q == CNT_W'(fxa_pkg::DIV_STEPS - 1));
      default:           last = 1'b0;
    endcase
  end

  // Latched input word and per-item indexes.
  logic [CW-1:0]      ch_q;
  logic               chan_q;
  logic signed [15:0] x_q, d_q;
  logic [LW-1:0]      rd_q, rp_q;
  logic [TW-1:0]      idx_q, fk_q, fk0_q;
  logic [TW-1:0]      wpos_q [NUM_CHANNELS];
  logic [AW-1:0]      base;
  logic [TW-1:0]      rp_t, rd_t, fk0, rp_inc;

  assign base   = AW'(ch_q) * AW'(MAX_TAPS);
  assign rp_t   = TW'(rp_q);
  assign rd_t   = TW'(rd_q);
  assign rp_inc = (rp_t == lm1) ? '0 : rp_t + TW'(1);

  // Remainder steps: one dividend bit per cycle for the delay and write position.
  logic [fxa_pkg::REM_STEPS-1:0] wp_ext;
  logic [3:0]                    bsel;
  logic [LW:0]                   rd2, rp2;
  logic [LW-1:0]                 rd_n, rp_n;
  always_comb begin
    wp_ext = fxa_pkg::REM_STEPS'(wpos_q[ch_q]);
    bsel   = 4'(fxa_pkg::REM_STEPS - 1) - cnt_q[3:0];
    rd2    = {rd_q, delay_q[bsel]};
    rp2    = {rp_q, wp_ext[bsel]};
    rd_n   = (rd2 >= (LW+1)'(len)) ? LW'(rd2 - (LW+1)'(len)) : LW'(rd2);
    rp_n   = (rp2 >= (LW+1)'(len)) ? LW'(rp2 - (LW+1)'(len)) : LW'(rp2);
    if (rp_t >= rd_t) fk0 = rp_t - rd_t;
    else fk0 = TW'((LW+1)'(rp_t) + (LW+1)'(len) - (LW+1)'(rd_t));
  end

  function automatic logic [TW-1:0] dec_wrap(input logic [TW-1:0] v, input logic [TW-1:0] top);
    return (v == '0) ? top : v - TW'(1);
  endfunction

  // Memories.
  logic signed [31:0] wmem [DEPTH];
  logic signed [15:0] hmem [DEPTH];
  logic signed [31:0] w_rd_q;
  logic signed [15:0] ha_rd_q, hb_rd_q;
  logic [AW-1:0]      w_ra, ha_ra, hb_ra, w_wa, h_wa;
  logic               w_we, h_we;
  logic signed [31:0] w_wd;
  logic signed [15:0] h_wd;
  logic               p2v6_q;
  logic [AW-1:0]      a6_q;
  logic signed [31:0] wn_q;

  assign w_ra  = base + AW'(k);
  assign ha_ra = base + AW'(idx_q);
  assign hb_ra = base + AW'(fk_q);

  always_comb begin
    if (op == fxa_pkg::OP_CLEAR) begin
      w_we = 1'b1; w_wa = cnt_q[AW-1:0]; w_wd = '0;
      h_we = 1'b1; h_wa = cnt_q[AW-1:0]; h_wd = '0;
    end else begin
      w_we = p2v6_q; w_wa = a6_q; w_wd = wn_q;
      h_we = (op == fxa_pkg::OP_SETUP); h_wa = base + AW'(rp_t); h_wd = x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_rd_q <= wmem[w_ra];
    if (w_we) wmem[w_wa] <= w_wd;
  end

  always_ff @(posedge clk_i) begin
    ha_rd_q <= hmem[ha_ra];
    hb_rd_q <= hmem[hb_ra];
    if (h_we) hmem[h_wa] <= h_wd;
  end

  // Pipeline valid bits: pass 1 has four stages, pass 2 six.
  logic p1v1_q, p1v2_q, p1v3_q, p1v4_q;
  logic p2v1_q, p2v2_q, p2v3_q, p2v4_q, p2v5_q;
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      p1v1_q      <= 1'b0;
      p1v2_q      <= 1'b0;
      p1v3_q      <= 1'b0;
      p1v4_q      <= 1'b0;
      p2v1_q      <= 1'b0;
      p2v2_q      <= 1'b0;
      p2v3_q      <= 1'b0;
      p2v4_q      <= 1'b0;
      p2v5_q      <= 1'b0;
      p2v6_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) wpos_q[i] <= '0;
    end else begin
      cnt_q  <= cnt_d;
      p1v1_q <= (op == fxa_pkg::OP_PASS1);
      p1v2_q <= p1v1_q;
      p1v3_q <= p1v2_q;
      p1v4_q <= p1v3_q;
      p2v1_q <= (op == fxa_pkg::OP_PASS2);
      p2v2_q <= p2v1_q;
      p2v3_q <= p2v2_q;
      p2v4_q <= p2v3_q;
      p2v5_q <= p2v4_q;
      p2v6_q <= p2v5_q;
      if (op == fxa_pkg::OP_OUT) begin
        out_valid_q  <= 1'b1;
        wpos_q[ch_q] <= rp_inc;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Arithmetic registers.
  logic signed [47:0]        prod_q;
  logic signed [32:0]        gh_q;
  logic signed [48:0]        lw_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [19:0]        xf_q;
  logic signed [34:0]        lwr_q, lwr3_q, lwr4_q;
  logic [39:0]               sq_q;
  logic [NORM_W-1:0]         norm_q;
  logic [47:0]               pl_q, ph_q;
  logic                      dneg_q, dneg4_q, azero_q, sneg_q;
  logic [40:0]               delta_q;
  logic [AW-1:0]             a1_q, a2_q, a3_q, a4_q, a5_q;
  logic signed [YQ_W-1:0]    yq_q;
  logic signed [GY_W-1:0]    gy_q;
  logic signed [15:0]        e_q, anti_q;
  logic [63:0]               dq_q;
  logic [DEN_W-1:0]          rem_q, den_q;
  logic                      out_ch_q;

  logic [18:0]               af;
  logic [63:0]               sc;
  logic                      sc_big;
  logic [76:0]               pfull;
  logic [58:0]               raw;
  logic [40:0]               delta_n;
  logic signed [42:0]        wsum;
  logic signed [WW-1:0]      err_t;
  logic signed [32:0]        me;
  logic [31:0]               mag;
  logic [DEN_W:0]            r2;
  logic                      ge;

  always_comb begin
    af      = xf_q[19] ? 19'(-xf_q) : 19'(xf_q);
    sc      = (den_q == '0) ? '0 : dq_q;
    sc_big  = |sc[63:58];
    pfull   = {ph_q, 29'b0} + 77'(pl_q);
    raw     = 59'((pfull + 77'(1 << 17)) >> 18);
    if (azero_q) delta_n = '0;
    else if (sc_big || (raw > 59'(41'h100_0000_0000))) delta_n = 41'h100_0000_0000;
    else delta_n = raw[40:0];
    wsum    = dneg4_q ? 43'(lwr4_q) - 43'(delta_q) : 43'(lwr4_q) + 43'(delta_q);
    err_t   = (WW'(d_q) <<< 12) - WW'(gy_q);
    me      = $signed({1'b0, step_q}) * e_q;
    mag     = me[32] ? 32'(-me) : 32'(me);
    r2      = {rem_q, dq_q[63]};
    ge      = (r2 >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i) begin
    // Stage 1: products of the read data.
    if (p1v1_q || p2v1_q) begin
      prod_q <= w_rd_q * ha_rd_q;
      gh_q   <= $signed({1'b0, gain_q}) * hb_rd_q;
      lw_q   <= $signed({1'b0, leak_q}) * w_rd_q;
      a2_q   <= a1_q;
    end
    // Stage 2: accumulate the filter output and round the filtered-x and leaked-weight terms.
    if (p1v2_q) acc_q <= acc_q + ACC_W'(prod_q);
    if (p1v2_q || p2v2_q) begin
      xf_q  <= 20'(fxa_pkg::rnd(WW'(gh_q), 12));
      lwr_q <= 35'(fxa_pkg::rnd(WW'(lw_q), 15));
      a3_q  <= a2_q;
    end
    // Stage 3: energy term, or the split product of scale and filtered-x.
    if (p1v3_q) sq_q <= 40'(40'(xf_q) * 40'(xf_q));
    if (p2v3_q) begin
      pl_q    <= 48'(sc[28:0]) * 48'(af);
      ph_q    <= 48'(sc[57:29]) * 48'(af);
      dneg_q  <= sneg_q ^ xf_q[19];
      azero_q <= (xf_q == '0);
      lwr3_q  <= lwr_q;
      a4_q    <= a3_q;
    end
    if (p1v4_q) norm_q <= norm_q + NORM_W'(sq_q);
    // Stage 4: rounded and limited weight step.
    if (p2v4_q) begin
      delta_q <= delta_n;
      dneg4_q <= dneg_q;
      lwr4_q  <= lwr3_q;
      a5_q    <= a4_q;
    end
    // Stage 5: leaked weight plus step, saturated; written back next cycle.
    if (p2v5_q) begin
      wn_q <= fxa_pkg::sat32(WW'(wsum));
      a6_q <= a5_q;
    end

    if ((op == fxa_pkg::OP_PASS1) || (op == fxa_pkg::OP_PASS2)) a1_q <= w_ra;

    unique case (op)
      fxa_pkg::OP_LOAD: begin
        ch_q   <= (NUM_CHANNELS > 1) ? CW'(in_channel_i) : '0;
        chan_q <= in_channel_i;
        x_q    <= in_reference_sample_i;
        d_q    <= in_mic_sample_i;
        rd_q   <= '0;
        rp_q   <= '0;
      end
      fxa_pkg::OP_REM: begin
        rd_q <= rd_n;
        rp_q <= rp_n;
      end
      fxa_pkg::OP_SETUP: begin
        idx_q  <= rp_t;
        fk_q   <= fk0;
        fk0_q  <= fk0;
        acc_q  <= '0;
        norm_q <= '0;
      end
      fxa_pkg::OP_PASS1: begin
        idx_q <= dec_wrap(idx_q, lm1);
        fk_q  <= dec_wrap(fk_q, lm1);
      end
      fxa_pkg::OP_YQ:  yq_q <= YQ_W'(fxa_pkg::rnd(WW'(acc_q), 28));
      fxa_pkg::OP_GY:  gy_q <= $signed({1'b0, gain_q}) * yq_q;
      fxa_pkg::OP_ERR: begin
        e_q    <= fxa_pkg::sat16(fxa_pkg::rnd(err_t, 12));
        anti_q <= fxa_pkg::sat16(-WW'(yq_q));
      end
      fxa_pkg::OP_ME: begin
        sneg_q <= me[32];
        dq_q   <= {mag, 32'b0};
        rem_q  <= '0;
        den_q  <= DEN_W'(norm_q) + DEN_W'(eps_q);
        fk_q   <= fk0_q;
      end
      fxa_pkg::OP_DIV: begin
        rem_q <= ge ? DEN_W'(r2 - {1'b0, den_q}) : DEN_W'(r2);
        dq_q  <= {dq_q[62:0], ge};
      end
      fxa_pkg::OP_PASS2: fk_q <= dec_wrap(fk_q, lm1);
      fxa_pkg::OP_OUT: out_ch_q <= chan_q;
      default: ;
    endcase
  end

  logic signed [15:0] out_anti_q, out_res_q;
  always_ff @(posedge clk_i) begin
    if (op == fxa_pkg::OP_OUT) begin
      out_anti_q <= anti_q;
      out_res_q  <= e_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_ch_q;
  assign out_anti_noise_o = out_anti_q;
  assign out_residual_o   = out_res_q;

  assign status_o.last       = last;
  assign status_o.pipe_empty = !(p1v1_q || p1v2_q || p1v3_q || p1v4_q || p2v1_q || p2v2_q ||
                                 p2v3_q || p2v4_q || p2v5_q || p2v6_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

@@ rtl/fxlms_anc_adaptive_filter.sv @@
// Filtered-x normalized LMS noise canceller with a sequencer and a shared-MAC datapath.
// Each word runs through ten remainder steps, a filter pass of L reads for L taps in use,
// a 64-step divider and an update pass of L.
// One word is in work at a time; the next is taken while a result waits in the output register.
// After reset a clearing pass over all NUM_CHANNELS*MAX_TAPS entries zeroes weights and history;
// no word is taken during it, while configuration writes are always accepted.
module fxlms_anc_adaptive_filter #(
  parameter int unsigned MAX_TAPS     = fxa_pkg::MAX_TAPS_DEF,
  parameter int unsigned NUM_CHANNELS = fxa_pkg::NUM_CH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fxa_in_if.sink    in_i,
  fxa_out_if.source out_o,
  fxa_cfg_if.sink   cfg_i
);

  fxa_pkg::dp_cmd_t    cmd;
  fxa_pkg::dp_status_t status;

  assign cfg_i.ready = 1'b1;

  fxa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fxa_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .in_channel_i          (in_i.channel),
    .in_reference_sample_i (in_i.reference_sample),
    .in_mic_sample_i       (in_i.mic_sample),
    .out_valid_o           (out_o.valid),
    .out_ready_i           (out_o.ready),
    .out_channel_o         (out_o.out_channel),
    .out_anti_noise_o      (out_o.anti_noise),
    .out_residual_o        (out_o.residual),
    .cfg_valid_i           (cfg_i.valid),
    .cfg_index_i           (cfg_i.index),
    .cfg_data_i            (cfg_i.data)
  );

endmodule
